// ----- rtl/tqss_pkg.sv -----
// ----------------------------------------------------------------------------
// tqss_pkg
// Shared types and constants for the two-queue swap scheduler.
// ----------------------------------------------------------------------------
package tqss_pkg;

  // Number of process IDs; this sets the status table and queue depths.
  localparam int NUM_IDS  = 256;
  localparam int PTR_W    = $clog2(NUM_IDS);
  localparam int CNT_W    = $clog2(NUM_IDS + 1);
  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;

  // Per-process status codes.
  localparam logic [STATUS_W-1:0] STAT_NEW    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_WAITED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RAN    = 2'd2;

  typedef enum logic [1:0] {
    FUNC_NEW      = 2'd0,
    FUNC_READY    = 2'd1,
    FUNC_WAITING  = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_e;

  typedef struct packed {
    func_e           func;
    logic [ID_W-1:0] process_id;
  } sched_in_t;

  typedef struct packed {
    logic [ID_W-1:0] chosen_id;
    logic            found;
    logic            dropped;
  } sched_out_t;

  // Request from the control logic to the run queues.
  typedef struct packed {
    logic            push;
    logic            to_cur;
    logic            pop;
    logic [ID_W-1:0] id;
  } q_req_t;

  // Same-cycle answer from the run queues.
  typedef struct packed {
    logic found;
    logic dropped;
  } q_rsp_t;

endpackage

// ----- rtl/two_queue_swap_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// two_queue_swap_scheduler_top
// Process scheduler with a current and a next run queue and a status table.
// ----------------------------------------------------------------------------
// New, waiting and dispatch on empty queues give their result word in the
// cycle after acceptance; ready and a successful dispatch first pass a wait
// state, as the status table or the queue store has a registered read port.
// Input is held off during a wait state and while a result waits untaken.
// Reset: pointers, counts, queue roles and the status valid bits clear at once,
// so every ID reads as new; the queue stores are not cleared and need no pass.
module two_queue_swap_scheduler_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tqss_pkg::sched_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tqss_pkg::sched_out_t out_data_o
);

  localparam int PTR_W = tqss_pkg::PTR_W;

  // One-hot sequencer: idle, waiting on a status read, waiting on a queue read.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STAT = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // The ID of the word in flight, kept for the S_STAT state of a ready word.
  logic [tqss_pkg::ID_W-1:0] id_q, id_d;

  // Output register; a result waiting in it holds off the input until taken.
  logic                 out_valid_q, out_valid_d;
  tqss_pkg::sched_out_t out_q, out_d;
  logic                 out_load;

  // Status table: RAM plus one valid bit per ID so unwritten IDs read as new.
  logic [tqss_pkg::NUM_IDS-1:0]  stat_vld_q, stat_vld_d;
  logic                          st_we, st_re;
  logic [PTR_W-1:0]              st_waddr, id_addr, id_addr_q;
  logic [tqss_pkg::STATUS_W-1:0] st_wdata, st_rdata, st_cur;

  tqss_pkg::q_req_t          q_req;
  tqss_pkg::q_rsp_t          q_rsp;
  logic [tqss_pkg::ID_W-1:0] pop_id;

  logic accept, id_ok, pop_ok;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign id_addr    = PTR_W'(in_data_i.process_id);
  assign id_addr_q  = PTR_W'(id_q);
  assign id_ok      = (32'(in_data_i.process_id) < 32'(tqss_pkg::NUM_IDS));
  assign pop_ok     = (32'(pop_id) < 32'(tqss_pkg::NUM_IDS));
  // An ID that was never written holds the reset status, new.
  assign st_cur     = stat_vld_q[id_addr_q] ? st_rdata : tqss_pkg::STAT_NEW;

  // Queue requests depend only on the state, the status read and the input,
  // so the same-cycle queue answer can feed the sequencer below without a loop.
  always_comb begin
    q_req = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.func)
            tqss_pkg::FUNC_NEW: begin
              // A new process is always new, so it joins the current queue.
              if (id_ok) begin
                q_req.push   = 1'b1;
                q_req.to_cur = 1'b1;
                q_req.id     = in_data_i.process_id;
              end
            end
            tqss_pkg::FUNC_DISPATCH: begin
              q_req.pop = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_STAT: begin
        // A process that already ran this round goes to the next queue.
        q_req.push   = 1'b1;
        q_req.to_cur = (st_cur != tqss_pkg::STAT_RAN);
        q_req.id     = id_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    id_d     = id_q;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_waddr = id_addr;
    st_wdata = tqss_pkg::STAT_NEW;
    out_load = 1'b0;
    out_d    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d = in_data_i.process_id;
          case (in_data_i.func)
            tqss_pkg::FUNC_NEW: begin
              out_load = 1'b1;
              if (id_ok) begin
                st_we         = 1'b1;
                st_wdata      = tqss_pkg::STAT_NEW;
                out_d.dropped = q_rsp.dropped;
              end
            end
            tqss_pkg::FUNC_READY: begin
              // The target queue depends on the status, read next cycle.
              if (id_ok) begin
                st_re   = 1'b1;
                state_d = S_STAT;
              end else begin
                out_load = 1'b1;
              end
            end
            tqss_pkg::FUNC_WAITING: begin
              out_load = 1'b1;
              if (id_ok) begin
                st_we    = 1'b1;
                st_wdata = tqss_pkg::STAT_WAITED;
              end
            end
            tqss_pkg::FUNC_DISPATCH: begin
              if (q_rsp.found) begin
                state_d = S_POP;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_STAT: begin
        out_load      = 1'b1;
        out_d.dropped = q_rsp.dropped;
        state_d       = S_IDLE;
      end
      S_POP: begin
        // The popped ID comes out of the queue store now; mark it as ran.
        if (pop_ok) begin
          st_we    = 1'b1;
          st_waddr = PTR_W'(pop_id);
          st_wdata = tqss_pkg::STAT_RAN;
        end
        out_load        = 1'b1;
        out_d.chosen_id = pop_id;
        out_d.found     = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    stat_vld_d = stat_vld_q;
    if (st_we) begin
      stat_vld_d[st_waddr] = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      stat_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      stat_vld_q  <= stat_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  tqss_ram #(
    .Width(tqss_pkg::STATUS_W),
    .Depth(tqss_pkg::NUM_IDS)
  ) u_status (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(id_addr),
    .rdata_o(st_rdata)
  );

  tqss_queues u_queues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (q_req),
    .rsp_o   (q_rsp),
    .pop_id_o(pop_id)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result must never overwrite one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before it was taken");

  // Every wait state is followed directly by idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (state_q == S_IDLE))
    else $error("sequencer stuck outside idle");

  // A successful dispatch always delivers a found word right after S_POP.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (out_valid_q && out_q.found && !out_q.dropped))
    else $error("dispatch result lost");

  // Queue pushes and pops never happen in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_req.push && q_req.pop))
    else $error("push and pop requested together");

endmodule

// ----- rtl/tqss_ram.sv -----
// ----------------------------------------------------------------------------
// tqss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tqss_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tqss_queues.sv -----
// ----------------------------------------------------------------------------
// tqss_queues
// The two run queues (A and B) with their pointers, counts and role flag.
// ----------------------------------------------------------------------------
module tqss_queues (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tqss_pkg::q_req_t          req_i,
  output tqss_pkg::q_rsp_t          rsp_o,
  output logic [tqss_pkg::ID_W-1:0] pop_id_o
);

  localparam int PTR_W = tqss_pkg::PTR_W;
  localparam int CNT_W = tqss_pkg::CNT_W;

  logic [PTR_W-1:0] head_a_q, head_a_d, tail_a_q, tail_a_d;
  logic [PTR_W-1:0] head_b_q, head_b_d, tail_b_q, tail_b_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic             cur_b_q, cur_b_d;
  logic             pop_b_q, pop_b_d;

  logic [CNT_W-1:0] cnt_cur, pop_cnt, push_cnt;
  logic             cur_empty, pop_b, push_b, push_full, pop_go, push_go;
  logic [tqss_pkg::ID_W-1:0] rdata_a, rdata_b;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    nxt = (ptr == PTR_W'(tqss_pkg::NUM_IDS - 1)) ? '0 : ptr + PTR_W'(1);
    return nxt;
  endfunction

  always_comb begin
    cnt_cur   = cur_b_q ? cnt_b_q : cnt_a_q;
    cur_empty = (cnt_cur == '0);
    // A dispatch on an empty current queue swaps the roles first.
    pop_b     = cur_b_q ^ cur_empty;
    pop_cnt   = pop_b ? cnt_b_q : cnt_a_q;
    pop_go    = req_i.pop && (pop_cnt != '0);

    push_b    = req_i.to_cur ? cur_b_q : ~cur_b_q;
    push_cnt  = push_b ? cnt_b_q : cnt_a_q;
    push_full = (push_cnt == CNT_W'(tqss_pkg::NUM_IDS));
    push_go   = req_i.push && !push_full;

    rsp_o.found   = pop_go;
    rsp_o.dropped = req_i.push && push_full;

    head_a_d = head_a_q;
    head_b_d = head_b_q;
    tail_a_d = tail_a_q;
    tail_b_d = tail_b_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    cur_b_d  = (req_i.pop && cur_empty) ? ~cur_b_q : cur_b_q;
    pop_b_d  = pop_go ? pop_b : pop_b_q;

    // Push and pop never arrive in the same cycle.
    if (push_go) begin
      if (push_b) begin
        tail_b_d = next_ptr(tail_b_q);
        cnt_b_d  = cnt_b_q + CNT_W'(1);
      end else begin
        tail_a_d = next_ptr(tail_a_q);
        cnt_a_d  = cnt_a_q + CNT_W'(1);
      end
    end
    if (pop_go) begin
      if (pop_b) begin
        head_b_d = next_ptr(head_b_q);
        cnt_b_d  = cnt_b_q - CNT_W'(1);
      end else begin
        head_a_d = next_ptr(head_a_q);
        cnt_a_d  = cnt_a_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q <= '0;
      tail_a_q <= '0;
      cnt_a_q  <= '0;
      head_b_q <= '0;
      tail_b_q <= '0;
      cnt_b_q  <= '0;
      cur_b_q  <= 1'b0;
      pop_b_q  <= 1'b0;
    end else begin
      head_a_q <= head_a_d;
      tail_a_q <= tail_a_d;
      cnt_a_q  <= cnt_a_d;
      head_b_q <= head_b_d;
      tail_b_q <= tail_b_d;
      cnt_b_q  <= cnt_b_d;
      cur_b_q  <= cur_b_d;
      pop_b_q  <= pop_b_d;
    end
  end

  tqss_ram #(
    .Width(tqss_pkg::ID_W),
    .Depth(tqss_pkg::NUM_IDS)
  ) u_store_a (
    .clk_i  (clk_i),
    .we_i   (push_go && !push_b),
    .waddr_i(tail_a_q),
    .wdata_i(req_i.id),
    .re_i   (pop_go && !pop_b),
    .raddr_i(head_a_q),
    .rdata_o(rdata_a)
  );

  tqss_ram #(
    .Width(tqss_pkg::ID_W),
    .Depth(tqss_pkg::NUM_IDS)
  ) u_store_b (
    .clk_i  (clk_i),
    .we_i   (push_go && push_b),
    .waddr_i(tail_b_q),
    .wdata_i(req_i.id),
    .re_i   (pop_go && pop_b),
    .raddr_i(head_b_q),
    .rdata_o(rdata_b)
  );

  assign pop_id_o = pop_b_q ? rdata_b : rdata_a;

endmodule

// ----- tb/sched_checker.sv -----
// ----------------------------------------------------------------------------
// sched_checker
// Watches both channels of the scheduler, predicts every result word from the
// accepted input words and compares the two field by field.
// ----------------------------------------------------------------------------
module sched_checker
  import tqss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  sched_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  sched_out_t out_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         found_o,
  output int         dropped_o
);

  // Our own copy of the scheduler state. Index 0 is queue A, index 1 is B.
  logic [STATUS_W-1:0] proc_status [NUM_IDS];
  logic [ID_W-1:0]     run_store   [2][NUM_IDS];
  logic [PTR_W-1:0]    run_head    [2];
  logic [PTR_W-1:0]    run_tail    [2];
  int                  run_count   [2];
  bit                  cur_q;

  sched_out_t expected_words [$];
  int         fails;
  int         checked;
  int         found_hits;
  int         drop_hits;

  initial begin
    foreach (proc_status[i]) proc_status[i] = STAT_NEW;
    run_head  = '{default: '0};
    run_tail  = '{default: '0};
    run_count = '{default: 0};
    cur_q      = 1'b0;
    fails      = 0;
    checked    = 0;
    found_hits = 0;
    drop_hits  = 0;
  end

  // Returns 1 when the queue was full and the ID was discarded.
  function automatic bit push_run(bit q, logic [ID_W-1:0] id);
    if (run_count[q] >= NUM_IDS) return 1'b1;
    run_store[q][run_tail[q]] = id;
    run_tail[q]++;
    run_count[q]++;
    return 1'b0;
  endfunction

  function automatic sched_out_t schedule_word(sched_in_t w);
    sched_out_t r;
    bit         to_next;
    r = '0;
    if (w.func == FUNC_DISPATCH) begin
      // An empty current queue swaps roles before the pop is tried.
      if (run_count[cur_q] == 0) cur_q = !cur_q;
      if (run_count[cur_q] != 0) begin
        r.chosen_id = run_store[cur_q][run_head[cur_q]];
        r.found     = 1'b1;
        run_head[cur_q]++;
        run_count[cur_q]--;
        proc_status[r.chosen_id] = STAT_RAN;
      end
    end else if (int'(w.process_id) < NUM_IDS) begin
      case (w.func)
        FUNC_NEW: begin
          proc_status[w.process_id] = STAT_NEW;
          r.dropped = push_run(cur_q, w.process_id);
        end
        FUNC_READY: begin
          to_next   = (proc_status[w.process_id] == STAT_RAN);
          r.dropped = push_run(to_next ? !cur_q : cur_q, w.process_id);
        end
        default: proc_status[w.process_id] = STAT_WAITED;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    sched_out_t want;
    if (rst_ni) begin
      // Compare first: a word accepted at this edge cannot answer itself.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("ERROR: result word with nothing expected: id=%0d found=%0b dropped=%0b",
                     out_data_i.chosen_id, out_data_i.found, out_data_i.dropped);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_data_i.found === 1'b1) found_hits++;
          if (out_data_i.dropped === 1'b1) drop_hits++;
          if (out_data_i.chosen_id !== want.chosen_id || out_data_i.found !== want.found ||
              out_data_i.dropped !== want.dropped) begin
            fails++;
            if (fails <= 10)
              $display("ERROR: word %0d: expected id=%0d found=%0b dropped=%0b, got id=%0d found=%0b dropped=%0b",
                       checked, want.chosen_id, want.found, want.dropped,
                       out_data_i.chosen_id, out_data_i.found, out_data_i.dropped);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(schedule_word(in_data_i));
    end
    fail_count_o <= fails;
    pending_o    <= expected_words.size();
    checked_o    <= checked;
    found_o      <= found_hits;
    dropped_o    <= drop_hits;
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-queue swap scheduler: a directed opening,
// runs that fill each queue past capacity, and a random mix of all four
// operations under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import tqss_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  sched_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  sched_out_t out_data_o;

  int fail_count;
  int pending_results;
  int results_checked;
  int found_count;
  int dropped_count;
  int words_sent;

  // Both are changed with nonblocking writes at the falling edge, so the
  // receiver process never sees a change at the edge that wrote it, no matter
  // which of the two processes wakes first.
  idle_mode_e idle_mode;
  bit         hold_go;

  two_queue_swap_scheduler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  sched_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (results_checked),
    .found_o      (found_count),
    .dropped_o    (dropped_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // A hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit draw_idle(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver side. Outside the long hold it stalls according to the idle
  // mode. The hold keeps ready low so the block backs up and must drop
  // in_ready_o while the sender keeps offering words.
  initial begin
    int hold_left;
    bit hold_used;
    int stall_pct;
    hold_left   = 0;
    hold_used   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 48 : (idle_mode == IDLE_BOTH) ? 10 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !draw_idle(stall_pct);
      end
    end
  end

  // Offers one word and returns at the falling edge after it was taken.
  // Valid is left high so back-to-back words need no drop in between.
  task automatic send_word(input func_e op, input logic [ID_W-1:0] id);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 48 : (idle_mode == IDLE_BOTH) ? 10 : 0;
    while (draw_idle(gap_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: op, process_id: id};
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Lets every expected word come back before the next phase starts.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_words(input int count);
    int pick;
    logic [ID_W-1:0] id;
    repeat (count) begin
      pick = $urandom_range(99);
      // A quarter of the IDs come from a tiny pool so that repeats, status
      // changes on queued IDs and duplicate queue entries happen often.
      id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(255));
      if (pick < 25)      send_word(FUNC_NEW, id);
      else if (pick < 55) send_word(FUNC_READY, id);
      else if (pick < 70) send_word(FUNC_WAITING, id);
      else                send_word(FUNC_DISPATCH, id);
    end
  endtask

  initial begin
    words_sent = 0;
    idle_mode  = IDLE_NONE;
    hold_go    = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening. Queue contents after each step are in the comments;
    // it ends with both queues empty and queue B as the current one.
    send_word(FUNC_NEW, 8'h00);          // A: 00
    send_word(FUNC_NEW, 8'hFF);          // A: 00 FF
    send_word(FUNC_NEW, 8'hAA);
    send_word(FUNC_NEW, 8'h55);
    send_word(FUNC_WAITING, 8'h03);
    send_word(FUNC_READY, 8'h03);        // a waited ID goes to the current queue
    send_word(FUNC_DISPATCH, 8'h00);     // pops 00, which is now marked ran
    send_word(FUNC_DISPATCH, 8'hFF);     // the ID field is ignored on dispatch
    send_word(FUNC_DISPATCH, 8'h5A);
    send_word(FUNC_DISPATCH, 8'hA5);
    send_word(FUNC_READY, 8'h00);        // a ran ID goes to the next queue
    send_word(FUNC_READY, 8'hFF);        // B: 00 FF
    send_word(FUNC_WAITING, 8'hFF);
    send_word(FUNC_DISPATCH, 8'h00);     // pops 03, A is empty now
    send_word(FUNC_DISPATCH, 8'h00);     // swap, B is current, pops 00
    send_word(FUNC_READY, 8'hFF);        // waited, so onto current B twice over
    send_word(FUNC_DISPATCH, 8'h00);
    send_word(FUNC_DISPATCH, 8'h00);     // the duplicate copy of FF
    send_word(FUNC_DISPATCH, 8'h00);     // both empty: swap, nothing found
    send_word(FUNC_DISPATCH, 8'h00);     // and once more from the other side
    send_word(FUNC_READY, 8'h0F);        // new status, onto the current queue
    send_word(FUNC_DISPATCH, 8'hFF);
    drain_results();

    // Fill the current queue past capacity; the last four are dropped. The
    // receiver holds off through most of this, so the block fills and stalls.
    hold_go <= 1'b1;
    for (int i = 0; i < NUM_IDS + 4; i++) send_word(FUNC_NEW, ID_W'(i));
    idle_mode <= IDLE_RECEIVER;
    repeat (NUM_IDS) send_word(FUNC_DISPATCH, ID_W'($urandom_range(255)));
    drain_results();

    // Every ID has run now, so ready words all land on the next queue and
    // overflow it; the drain then starts with a role swap.
    idle_mode <= IDLE_SENDER;
    repeat (NUM_IDS + 4) send_word(FUNC_READY, ID_W'($urandom_range(255)));
    idle_mode <= IDLE_BOTH;
    repeat (NUM_IDS) send_word(FUNC_DISPATCH, ID_W'($urandom_range(255)));
    drain_results();

    // Random mix under each idling pattern in turn.
    idle_mode <= IDLE_NONE;
    random_words(100);
    idle_mode <= IDLE_SENDER;
    random_words(100);
    idle_mode <= IDLE_RECEIVER;
    random_words(100);
    idle_mode <= IDLE_BOTH;
    random_words(100);
    idle_mode <= IDLE_NONE;
    drain_results();

    $display("Run covered %0d input words and %0d checked result words.",
             words_sent, results_checked);
    $display("Dispatches that found a process: %0d, enqueues dropped on a full queue: %0d.",
             found_count, dropped_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
